// ===== rtl/qsrs_pkg.sv =====
// Package: shared constants, types and controller/datapath command and status structs.
`default_nettype none
package qsrs_pkg;
   localparam int MaxRecords = 64;
   localparam int IdxW = $clog2(MaxRecords);
   localparam int CntW = $clog2(MaxRecords + 1);
   localparam int KeyW = 32;
   localparam int TagW = 16;
   localparam int RecW = KeyW + TagW;

   typedef logic [IdxW-1:0] idx_type;
   typedef logic [CntW-1:0] cnt_type;

   typedef enum logic [3:0] {
      MEM_NONE   = 4'd0,
      MEM_LOAD   = 4'd1,
      MEM_RD_LO  = 4'd2,
      MEM_RD_HI  = 4'd3,
      MEM_WR_LO  = 4'd4,
      MEM_WR_HI  = 4'd5,
      MEM_RD_OUT = 4'd6,
      MEM_RD_PIV = 4'd7,
      MEM_WR_PIV = 4'd8
   } mem_op_type;

   typedef struct packed {
      mem_op_type op;
      idx_type    addr;
      logic       hold_write;
   } dp_cmd_type;

   typedef struct packed {
      logic signed [KeyW-1:0] rd_key;
      logic signed [KeyW-1:0] piv_key;
   } dp_sts_type;
endpackage
`default_nettype wire

// ===== rtl/quicksort_record_sorter_core.sv =====
// Top level: record sorter, quicksort with hole partition over an internal store.
// Channel | Ports                                       | Direction
// req     | req_valid/ready, req_key, req_tag, req_last_item | in
// rsp     | rsp_valid/ready, rsp_sorted_key, rsp_sorted_tag, rsp_last_result, rsp_overflowed | out
// Loading takes one item per cycle. After the last item the sort runs on the single-port
// store; presorted keys are its slowest case, and mixed keys sort faster.
// Each result goes through a store read, a hold and a present step, plus the consumer's wait.
// Synchronous reset clears counts and control; the store is not cleared.
// No input is taken while sorting or emitting.
`default_nettype none
module quicksort_record_sorter_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [qsrs_pkg::KeyW-1:0]  req_key,
   input  wire logic [qsrs_pkg::TagW-1:0]         req_tag,
   input  wire logic                              req_last_item,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [qsrs_pkg::KeyW-1:0]       rsp_sorted_key,
   output logic [qsrs_pkg::TagW-1:0]              rsp_sorted_tag,
   output logic                                   rsp_last_result,
   output logic                                   rsp_overflowed
);
   qsrs_pkg::dp_cmd_type cmd;
   qsrs_pkg::dp_sts_type sts;
   logic [qsrs_pkg::RecW-1:0] rd_rec;
   logic busy;

   qsrs_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_last_item,
      .rsp_valid, .rsp_ready, .rsp_last_result, .rsp_overflowed,
      .cmd, .sts, .busy
   );

   qsrs_datapath u_dp (
      .clock, .cmd, .load_rec({req_key, req_tag}), .sts, .rd_rec
   );

   assign rsp_sorted_key = rd_rec[qsrs_pkg::RecW-1 -: qsrs_pkg::KeyW];
   assign rsp_sorted_tag = rd_rec[qsrs_pkg::TagW-1:0];

   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("input and output active together");
   a_busy_ready: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready) else $error("ready while busy");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_result) |=> req_ready)
      else $error("no return to load after last result");
endmodule
`default_nettype wire

// ===== rtl/qsrs_datapath.sv =====
// Datapath: record store, pivot and hole registers, read data.
`default_nettype none
module qsrs_datapath (
   input  wire logic                            clock,
   input  wire qsrs_pkg::dp_cmd_type            cmd,
   input  wire logic [qsrs_pkg::RecW-1:0]       load_rec,
   output qsrs_pkg::dp_sts_type                 sts,
   output logic [qsrs_pkg::RecW-1:0]            rd_rec
);
   logic [qsrs_pkg::RecW-1:0] store_mem [qsrs_pkg::MaxRecords];
   logic [qsrs_pkg::RecW-1:0] rd_ff;
   logic [qsrs_pkg::RecW-1:0] piv_ff;
   logic [qsrs_pkg::RecW-1:0] hold_ff;
   logic [qsrs_pkg::RecW-1:0] wdata;

   always_comb begin
      case (cmd.op)
         qsrs_pkg::MEM_LOAD:   wdata = load_rec;
         qsrs_pkg::MEM_WR_PIV: wdata = piv_ff;
         default:              wdata = hold_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == qsrs_pkg::MEM_LOAD || cmd.op == qsrs_pkg::MEM_WR_LO ||
          cmd.op == qsrs_pkg::MEM_WR_HI || cmd.op == qsrs_pkg::MEM_WR_PIV) begin
         store_mem[cmd.addr] <= wdata;
      end
      rd_ff <= store_mem[cmd.addr];
   end

   // Pivot captured from the record read at the MEM_RD_PIV address; hold latches the read record on hold_write.
   logic piv_pend_ff;
   always_ff @(posedge clock) begin
      piv_pend_ff <= (cmd.op == qsrs_pkg::MEM_RD_PIV);
      if (piv_pend_ff) piv_ff <= rd_ff;
      if (cmd.hold_write) hold_ff <= rd_ff;
   end

   assign rd_rec = rd_ff;
   assign sts.rd_key = rd_ff[qsrs_pkg::RecW-1 -: qsrs_pkg::KeyW];
   assign sts.piv_key = piv_ff[qsrs_pkg::RecW-1 -: qsrs_pkg::KeyW];
endmodule
`default_nettype wire

// ===== rtl/qsrs_control.sv =====
// Controller: load, quicksort sequencing with range stack, result emission.
`default_nettype none
module qsrs_control (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_last_item,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_last_result,
   output logic                         rsp_overflowed,
   output qsrs_pkg::dp_cmd_type         cmd,
   input  wire qsrs_pkg::dp_sts_type    sts,
   output logic                         busy
);
   typedef enum logic [12:0] {
      S_LOAD   = 13'b0000000000001,
      S_POP    = 13'b0000000000010,
      S_PIV    = 13'b0000000000100,
      S_PIVW   = 13'b0000000001000,
      S_HRD    = 13'b0000000010000,
      S_HCMP   = 13'b0000000100000,
      S_LRD    = 13'b0000001000000,
      S_LCMP   = 13'b0000010000000,
      S_DONE   = 13'b0000100000000,
      S_PUSH   = 13'b0001000000000,
      S_ORD    = 13'b0010000000000,
      S_OWAIT  = 13'b0100000000000,
      S_OUT    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   qsrs_pkg::cnt_type count_ff, count_in;
   logic ovf_ff, ovf_in;
   qsrs_pkg::idx_type lo_ff, lo_in, hi_ff, hi_in, rlo_ff, rlo_in, rhi_ff, rhi_in;
   qsrs_pkg::cnt_type sp_ff, sp_in;
   qsrs_pkg::idx_type oi_ff, oi_in;
   logic push2_ff, push2_in;

   logic [2*qsrs_pkg::IdxW-1:0] stack_mem [qsrs_pkg::MaxRecords];
   logic [2*qsrs_pkg::IdxW-1:0] stk_rd_ff;
   logic stk_we;
   qsrs_pkg::idx_type stk_waddr, stk_raddr;
   logic [2*qsrs_pkg::IdxW-1:0] stk_wdata;

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
      stk_rd_ff <= stack_mem[stk_raddr];
   end

   logic key_ge, key_le;
   assign key_ge = sts.rd_key >= sts.piv_key;
   assign key_le = sts.rd_key <= sts.piv_key;

   qsrs_pkg::idx_type last_idx;
   assign last_idx = qsrs_pkg::IdxW'(count_ff - 1'b1);
   assign stk_raddr = qsrs_pkg::IdxW'(sp_ff - 1'b1);

   always_comb begin
      state_in = state_ff; count_in = count_ff; ovf_in = ovf_ff;
      lo_in = lo_ff; hi_in = hi_ff; rlo_in = rlo_ff; rhi_in = rhi_ff;
      sp_in = sp_ff; oi_in = oi_ff; push2_in = push2_ff;
      cmd = '{op: qsrs_pkg::MEM_NONE, addr: lo_ff, hold_write: 1'b0};
      req_ready = 1'b0; rsp_valid = 1'b0;
      stk_we = 1'b0; stk_waddr = sp_ff[qsrs_pkg::IdxW-1:0];
      stk_wdata = {lo_ff, hi_ff};
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            cmd.addr = count_ff[qsrs_pkg::IdxW-1:0];
            if (req_valid) begin
               if (count_ff < qsrs_pkg::CntW'(qsrs_pkg::MaxRecords)) begin
                  cmd.op = qsrs_pkg::MEM_LOAD;
                  count_in = count_ff + 1'b1;
               end else ovf_in = 1'b1;
               if (req_last_item) begin
                  oi_in = '0;
                  if (count_in >= qsrs_pkg::CntW'(2)) begin
                     stk_we = 1'b1; stk_waddr = '0;
                     stk_wdata = {{qsrs_pkg::IdxW{1'b0}}, qsrs_pkg::IdxW'(count_in - 1'b1)};
                     sp_in = qsrs_pkg::CntW'(1);
                     state_in = S_POP;
                  end else state_in = S_ORD;
               end
            end
         end
         S_POP: begin
            // stack read issued, data valid next cycle
            sp_in = sp_ff - 1'b1;
            state_in = S_PIV;
         end
         S_PIV: begin
            lo_in = stk_rd_ff[2*qsrs_pkg::IdxW-1 -: qsrs_pkg::IdxW];
            hi_in = stk_rd_ff[qsrs_pkg::IdxW-1:0];
            rlo_in = lo_in; rhi_in = hi_in;
            cmd.op = qsrs_pkg::MEM_RD_PIV; cmd.addr = lo_in;
            state_in = S_PIVW;
         end
         S_PIVW: begin
            state_in = S_HRD;
         end
         S_HRD: begin
            if (lo_ff < hi_ff) begin
               cmd.op = qsrs_pkg::MEM_RD_HI; cmd.addr = hi_ff;
               state_in = S_HCMP;
            end else state_in = S_DONE;
         end
         S_HCMP: begin
            if (key_ge) begin
               hi_in = hi_ff - 1'b1;
               state_in = S_HRD;
            end else begin
               cmd.hold_write = 1'b1;
               state_in = S_LRD;
            end
            if (key_ge && (hi_ff - 1'b1 == lo_ff)) state_in = S_DONE;
         end
         S_LRD: begin
            cmd.op = qsrs_pkg::MEM_WR_LO; cmd.addr = lo_ff;
            if (lo_ff < hi_ff) begin
               lo_in = lo_ff + 1'b1;
               state_in = S_LCMP;
            end else state_in = S_DONE;
         end
         S_LCMP: begin
            // issue read of lo (already incremented) then compare next cycle
            if (lo_ff < hi_ff) begin
               cmd.op = qsrs_pkg::MEM_RD_LO; cmd.addr = lo_ff;
               state_in = S_OWAIT;
               push2_in = 1'b0;
            end else state_in = S_DONE;
         end
         S_OWAIT: begin
            if (push2_ff) begin
               rsp_valid = 1'b0;
               cmd.addr = oi_ff;
               state_in = S_OUT;
            end else if (key_le) begin
               if (lo_ff + 1'b1 < hi_ff) begin
                  lo_in = lo_ff + 1'b1;
                  state_in = S_LCMP;
               end else begin
                  lo_in = hi_ff;
                  state_in = S_DONE;
               end
            end else begin
               cmd.hold_write = 1'b1;
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (push2_ff) begin
               stk_we = 1'b1;
               stk_wdata = {rlo_ff, qsrs_pkg::IdxW'(lo_ff - 1'b1)};
               sp_in = sp_ff + 1'b1;
               state_in = (sp_in == '0) ? S_ORD : S_POP;
               push2_in = 1'b0;
            end else begin
               cmd.op = qsrs_pkg::MEM_WR_HI; cmd.addr = hi_ff;
               hi_in = hi_ff - 1'b1;
               state_in = (lo_ff < hi_in) ? S_HRD : S_DONE;
            end
         end
         S_DONE: begin
            cmd.op = qsrs_pkg::MEM_WR_PIV; cmd.addr = lo_ff;
            if ({1'b0, lo_ff} + 1'b1 < {1'b0, rhi_ff}) begin
               stk_we = 1'b1;
               stk_wdata = {qsrs_pkg::IdxW'(lo_ff + 1'b1), rhi_ff};
               sp_in = sp_ff + 1'b1;
            end
            if (lo_ff > rlo_ff + 1'b1) begin
               push2_in = 1'b1;
               state_in = S_PUSH;
            end else state_in = (sp_in == '0) ? S_ORD : S_POP;
         end
         S_ORD: begin
            cmd.op = qsrs_pkg::MEM_RD_OUT; cmd.addr = oi_ff;
            push2_in = 1'b1;
            state_in = S_OWAIT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            cmd.addr = oi_ff;
            if (rsp_ready) begin
               push2_in = 1'b0;
               if (qsrs_pkg::CntW'(oi_ff) == qsrs_pkg::CntW'(last_idx)) begin
                  count_in = '0; ovf_in = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  oi_in = oi_ff + 1'b1;
                  state_in = S_ORD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   assign rsp_last_result = (oi_ff == last_idx);
   assign rsp_overflowed = ovf_ff;
   assign busy = (state_ff != S_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; count_ff <= '0; ovf_ff <= 1'b0; sp_ff <= '0;
         push2_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; ovf_ff <= ovf_in; sp_ff <= sp_in;
         push2_ff <= push2_in;
      end
      lo_ff <= lo_in; hi_ff <= hi_in; rlo_ff <= rlo_in; rhi_ff <= rhi_in; oi_ff <= oi_in;
   end
endmodule
`default_nettype wire

// ===== dv/quicksort_record_sorter_checker.sv =====
// Checker: predicts sorted runs from accepted items and compares each result item.
`timescale 1ns / 1ps
module quicksort_record_sorter_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_ready,
   input  wire logic signed [qsrs_pkg::KeyW-1:0] req_key,
   input  wire logic [qsrs_pkg::TagW-1:0]        req_tag,
   input  wire logic                             req_last_item,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire logic signed [qsrs_pkg::KeyW-1:0] rsp_sorted_key,
   input  wire logic [qsrs_pkg::TagW-1:0]        rsp_sorted_tag,
   input  wire logic                             rsp_last_result,
   input  wire logic                             rsp_overflowed,
   output int                                    fail_count,
   output int                                    pending_count
);
   typedef struct packed {
      logic signed [qsrs_pkg::KeyW-1:0] key;
      logic [qsrs_pkg::TagW-1:0]        tag;
      logic                             last;
      logic                             ovf;
   } sorted_rec_type;

   logic signed [qsrs_pkg::KeyW-1:0] keys [qsrs_pkg::MaxRecords];
   logic [qsrs_pkg::TagW-1:0]        tags [qsrs_pkg::MaxRecords];
   int                               held;
   bit                               dropped;
   sorted_rec_type                   sorted_q[$];

   function automatic int partition_range(int lo, int hi);
      logic signed [qsrs_pkg::KeyW-1:0] pk;
      logic [qsrs_pkg::TagW-1:0]        pt;
      pk = keys[lo];
      pt = tags[lo];
      while (lo < hi) begin
         while (lo < hi && keys[hi] >= pk) hi--;
         keys[lo] = keys[hi];
         tags[lo] = tags[hi];
         while (lo < hi && keys[lo] <= pk) lo++;
         keys[hi] = keys[lo];
         tags[hi] = tags[lo];
      end
      keys[lo] = pk;
      tags[lo] = pt;
      return lo;
   endfunction

   function automatic void sort_and_queue();
      int lo_s[$];
      int hi_s[$];
      int lo, hi, p;
      sorted_rec_type r;
      if (held >= 2) begin
         lo_s.push_back(0);
         hi_s.push_back(held - 1);
      end
      while (lo_s.size() > 0) begin
         lo = lo_s.pop_back();
         hi = hi_s.pop_back();
         p = partition_range(lo, hi);
         if (p + 1 < hi) begin
            lo_s.push_back(p + 1);
            hi_s.push_back(hi);
         end
         if (p > lo + 1) begin
            lo_s.push_back(lo);
            hi_s.push_back(p - 1);
         end
      end
      for (int i = 0; i < held; i++) begin
         r.key = keys[i];
         r.tag = tags[i];
         r.last = (i == held - 1);
         r.ovf = dropped;
         sorted_q.push_back(r);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      sorted_rec_type e;
      if (reset) begin
         held = 0;
         dropped = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sorted_q.size() == 0) begin
               report_mismatch("result item with none expected");
            end else begin
               e = sorted_q.pop_front();
               if (rsp_sorted_key !== e.key)
                  report_mismatch($sformatf("key %0d exp %0d", rsp_sorted_key, e.key));
               if (rsp_sorted_tag !== e.tag)
                  report_mismatch($sformatf("tag %0h exp %0h", rsp_sorted_tag, e.tag));
               if (rsp_last_result !== e.last)
                  report_mismatch($sformatf("last %0b exp %0b", rsp_last_result, e.last));
               if (rsp_overflowed !== e.ovf)
                  report_mismatch($sformatf("ovf %0b exp %0b", rsp_overflowed, e.ovf));
            end
         end
         if (req_valid && req_ready) begin
            if (held < qsrs_pkg::MaxRecords) begin
               keys[held] = req_key;
               tags[held] = req_tag;
               held = held + 1;
            end else begin
               dropped = 1;
            end
            if (req_last_item) begin
               sort_and_queue();
               held = 0;
               dropped = 0;
            end
         end
         pending_count = sorted_q.size();
      end
   end
endmodule

// ===== dv/quicksort_record_sorter_core_test.sv =====
// Testbench top: drives record sets into the sorter and gives the verdict.
`timescale 1ns / 1ps
module quicksort_record_sorter_core_test;
   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic signed [qsrs_pkg::KeyW-1:0] req_key;
   logic [qsrs_pkg::TagW-1:0]        req_tag;
   logic                             req_last_item;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic signed [qsrs_pkg::KeyW-1:0] rsp_sorted_key;
   logic [qsrs_pkg::TagW-1:0]        rsp_sorted_tag;
   logic                             rsp_last_result;
   logic                             rsp_overflowed;
   int                               fail_count;
   int                               pending_count;
   int                               cycle_count;
   bit                               stim_done;

   quicksort_record_sorter_core uut (.*);

   quicksort_record_sorter_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic int short_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic logic signed [qsrs_pkg::KeyW-1:0] rand_key(input int mode);
      case (mode)
         0: return $urandom_range(0, 7) - 4;
         1: return $urandom_range(0, 3) == 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input logic signed [qsrs_pkg::KeyW-1:0] k,
                            input logic [qsrs_pkg::TagW-1:0] t, input logic l);
      int g;
      g = short_gap();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1;
      req_key <= k;
      req_tag <= t;
      req_last_item <= l;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_set(input int n, input int mode);
      for (int i = 0; i < n; i++)
         send_item(rand_key(mode), qsrs_pkg::TagW'($urandom), i == n - 1);
   endtask

   initial begin
      int sent, n;
      req_valid = 0;
      req_key = 0;
      req_tag = 0;
      req_last_item = 0;
      stim_done = 0;
      reset = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;
      send_item(32'sh7fff_ffff, 16'hffff, 1);
      send_item(32'sh8000_0000, 16'h0000, 0);
      send_item(32'sh7fff_ffff, 16'h5555, 0);
      send_item(0, 16'haaaa, 0);
      send_item(-1, 16'h0001, 0);
      send_item(32'sh8000_0000, 16'h0002, 1);
      send_item(5, 16'd1, 0);
      send_item(5, 16'd2, 0);
      send_item(5, 16'd3, 1);
      for (int i = 0; i < 64; i++) send_item(64 - i, qsrs_pkg::TagW'(i), i == 63);
      for (int i = 0; i < 67; i++) send_item(i % 3, qsrs_pkg::TagW'(i), i == 66);
      for (int i = 0; i < 65; i++) send_item(i, qsrs_pkg::TagW'(i), i == 64);
      sent = 0;
      while (sent < 175) begin
         n = $urandom_range(0, 9) == 0 ? $urandom_range(30, 70) : $urandom_range(1, 12);
         send_set(n, $urandom_range(0, 3));
         sent += n;
      end
      req_valid <= 0;
      stim_done = 1;
   end

   initial begin
      int g;
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         g = ($urandom_range(0, 3) == 0) ? short_gap() : 0;
         if (g > 0) begin
            rsp_ready <= 0;
            repeat (g) @(negedge clock);
         end
         rsp_ready <= 1;
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 400000) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      wait (stim_done);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

// ===== quicksort_record_sorter_core.f =====
rtl/qsrs_pkg.sv
rtl/qsrs_datapath.sv
rtl/qsrs_control.sv
rtl/quicksort_record_sorter_core.sv
dv/quicksort_record_sorter_checker.sv
dv/quicksort_record_sorter_core_test.sv
